// ===== rtl/i2cms_pkg.sv =====
// Shared types and codes for the I2C master transfer sequencer.
`timescale 1ns / 1ps

package i2cms_pkg;

  localparam logic FUNC_BEGIN  = 1'b0;
  localparam logic FUNC_STATUS = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_START = 2'd1,
    PH_ADDR  = 2'd2,
    PH_DATA  = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_START   = 3'd1,
    CMD_TX      = 3'd2,
    CMD_RX_ACK  = 3'd3,
    CMD_RX_NACK = 3'd4,
    CMD_STOP    = 3'd5,
    CMD_RELEASE = 3'd6
  } cmd_t;

  typedef enum logic [2:0] {
    ST_START     = 3'd0,
    ST_RSTART    = 3'd1,
    ST_ARB_LOST  = 3'd2,
    ST_ADDR_ACK  = 3'd3,
    ST_ADDR_NACK = 3'd4,
    ST_DATA_ACK  = 3'd5,
    ST_DATA_NACK = 3'd6,
    ST_OTHER     = 3'd7
  } status_t;

  localparam logic [7:0] MAX_ATTEMPTS_RESET = 8'd200;

  typedef struct packed {
    logic       func;
    logic       is_read;
    logic [6:0] dev_addr;
    logic [15:0] byte_count;
    status_t    bus_status;
    logic [7:0] rx_byte;
    logic [7:0] tx_byte;
  } req_t;

  typedef struct packed {
    cmd_t        bus_cmd;
    logic [7:0]  shift_byte;
    logic        rx_valid;
    logic [7:0]  rx_data;
    logic        finished;
    logic        failed;
    logic [15:0] byte_total;
  } rsp_t;

  typedef struct packed {
    phase_t     phase;
    logic       read_mode;
    logic [7:0] attempts_made;
  } seq_stat_t;

endpackage

// ===== rtl/i2cms_fsm.sv =====
// Transfer state registers and the per-word decision logic.
`timescale 1ns / 1ps

module i2cms_fsm import i2cms_pkg::*; #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  req_t       word,
  input  logic [7:0] max_attempts,
  output rsp_t       result,
  output seq_stat_t  stat
);

  localparam int TW = (COUNT_WIDTH < 16) ? COUNT_WIDTH : 16;

  phase_t                 phase, phase_next;
  logic                   read_mode, read_mode_next;
  logic [6:0]             target_addr, target_addr_next;
  logic [COUNT_WIDTH-1:0] bytes_left, bytes_left_next;
  logic [COUNT_WIDTH-1:0] bytes_done, bytes_done_next;
  logic [7:0]             attempts_made, attempts_made_next;

  logic [COUNT_WIDTH-1:0] left_dec;
  logic [COUNT_WIDTH-1:0] done_inc;

  assign left_dec = bytes_left - 1'b1;
  assign done_inc = bytes_done + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      read_mode     <= 1'b0;
      target_addr   <= '0;
      bytes_left    <= '0;
      bytes_done    <= '0;
      attempts_made <= '0;
    end else if (fire) begin
      phase         <= phase_next;
      read_mode     <= read_mode_next;
      target_addr   <= target_addr_next;
      bytes_left    <= bytes_left_next;
      bytes_done    <= bytes_done_next;
      attempts_made <= attempts_made_next;
    end
  end

  always_comb begin
    phase_next         = phase;
    read_mode_next     = read_mode;
    target_addr_next   = target_addr;
    bytes_left_next    = bytes_left;
    bytes_done_next    = bytes_done;
    attempts_made_next = attempts_made;
    result             = '0;
    result.bus_cmd     = CMD_NONE;

    if (word.func == FUNC_BEGIN) begin
      // abandon anything running and latch the new transfer
      read_mode_next     = word.is_read;
      target_addr_next   = word.dev_addr;
      bytes_left_next    = COUNT_WIDTH'(word.byte_count);
      bytes_done_next    = '0;
      attempts_made_next = '0;
      if (word.is_read) begin
        result.bus_cmd = CMD_START;
        phase_next     = PH_START;
      end else if (max_attempts == 8'd0) begin
        result.finished = 1'b1;
        result.failed   = 1'b1;
        phase_next      = PH_IDLE;
      end else begin
        attempts_made_next = 8'd1;
        result.bus_cmd     = CMD_START;
        phase_next         = PH_START;
      end
    end else if (phase != PH_IDLE) begin
      if (read_mode) begin
        unique case (phase)
          PH_START: begin
            priority if (word.bus_status == ST_START || word.bus_status == ST_RSTART) begin
              result.bus_cmd    = CMD_TX;
              result.shift_byte = {target_addr, 1'b1};
              phase_next        = PH_ADDR;
            end else if (word.bus_status == ST_ARB_LOST) begin
              result.bus_cmd  = CMD_RELEASE;
              result.finished = 1'b1;
              result.failed   = 1'b1;
              phase_next      = PH_IDLE;
            end else begin
              result.bus_cmd  = CMD_STOP;
              result.finished = 1'b1;
              result.failed   = 1'b1;
              phase_next      = PH_IDLE;
            end
          end
          PH_ADDR: begin
            priority if (word.bus_status == ST_ADDR_ACK) begin
              phase_next = PH_DATA;
              priority if (bytes_left == '0) begin
                result.bus_cmd  = CMD_STOP;
                result.finished = 1'b1;
                phase_next      = PH_IDLE;
              end else if (left_dec == '0) begin
                result.bus_cmd = CMD_RX_NACK;
              end else begin
                result.bus_cmd = CMD_RX_ACK;
              end
            end else if (word.bus_status == ST_ADDR_NACK) begin
              result.bus_cmd  = CMD_STOP;
              result.finished = 1'b1;
              phase_next      = PH_IDLE;
            end else if (word.bus_status == ST_ARB_LOST) begin
              result.bus_cmd  = CMD_RELEASE;
              result.finished = 1'b1;
              result.failed   = 1'b1;
              phase_next      = PH_IDLE;
            end else begin
              result.bus_cmd  = CMD_STOP;
              result.finished = 1'b1;
              result.failed   = 1'b1;
              phase_next      = PH_IDLE;
            end
          end
          default: begin
            priority if (word.bus_status == ST_DATA_NACK) begin
              // last byte: keep it and stop
              result.rx_valid = 1'b1;
              result.rx_data  = word.rx_byte;
              bytes_done_next = done_inc;
              bytes_left_next = '0;
              result.bus_cmd  = CMD_STOP;
              result.finished = 1'b1;
              phase_next      = PH_IDLE;
            end else if (word.bus_status == ST_DATA_ACK) begin
              result.rx_valid = 1'b1;
              result.rx_data  = word.rx_byte;
              bytes_done_next = done_inc;
              bytes_left_next = left_dec;
              priority if (left_dec == '0) begin
                result.bus_cmd  = CMD_STOP;
                result.finished = 1'b1;
                phase_next      = PH_IDLE;
              end else if (left_dec == COUNT_WIDTH'(1)) begin
                result.bus_cmd = CMD_RX_NACK;
              end else begin
                result.bus_cmd = CMD_RX_ACK;
              end
            end else begin
              result.bus_cmd  = CMD_STOP;
              result.finished = 1'b1;
              result.failed   = 1'b1;
              phase_next      = PH_IDLE;
            end
          end
        endcase
      end else begin
        unique case (phase)
          PH_START: begin
            priority if (word.bus_status == ST_START || word.bus_status == ST_RSTART) begin
              result.bus_cmd    = CMD_TX;
              result.shift_byte = {target_addr, 1'b0};
              phase_next        = PH_ADDR;
            end else if (word.bus_status == ST_ARB_LOST) begin
              result.bus_cmd = CMD_START;
            end else begin
              // start never confirmed: give up without a stop
              result.finished = 1'b1;
              result.failed   = 1'b1;
              phase_next      = PH_IDLE;
            end
          end
          PH_ADDR: begin
            priority if (word.bus_status == ST_ADDR_ACK) begin
              if (bytes_left == '0) begin
                result.bus_cmd  = CMD_STOP;
                result.finished = 1'b1;
                phase_next      = PH_IDLE;
              end else begin
                result.bus_cmd    = CMD_TX;
                result.shift_byte = word.tx_byte;
                phase_next        = PH_DATA;
              end
            end else if (word.bus_status == ST_ADDR_NACK) begin
              // retry the whole selection while attempts remain
              if (attempts_made >= max_attempts) begin
                result.finished = 1'b1;
                result.failed   = 1'b1;
                phase_next      = PH_IDLE;
              end else begin
                attempts_made_next = attempts_made + 8'd1;
                result.bus_cmd     = CMD_START;
                phase_next         = PH_START;
              end
            end else if (word.bus_status == ST_ARB_LOST) begin
              result.bus_cmd = CMD_START;
              phase_next     = PH_START;
            end else begin
              result.bus_cmd  = CMD_STOP;
              result.finished = 1'b1;
              result.failed   = 1'b1;
              phase_next      = PH_IDLE;
            end
          end
          default: begin
            if (word.bus_status == ST_DATA_ACK) begin
              bytes_done_next = done_inc;
              bytes_left_next = left_dec;
              if (left_dec == '0) begin
                result.bus_cmd  = CMD_STOP;
                result.finished = 1'b1;
                phase_next      = PH_IDLE;
              end else begin
                result.bus_cmd    = CMD_TX;
                result.shift_byte = word.tx_byte;
              end
            end else begin
              result.bus_cmd  = CMD_STOP;
              result.finished = 1'b1;
              result.failed   = 1'b1;
              phase_next      = PH_IDLE;
            end
          end
        endcase
      end
    end

    result.byte_total = 16'(bytes_done_next[TW-1:0]);
  end

  assign stat.phase         = phase;
  assign stat.read_mode     = read_mode;
  assign stat.attempts_made = attempts_made;

endmodule

// ===== rtl/i2c_master_transfer_sequencer.sv =====
// Top level: input register, sequencer state logic, result register, attempt limit.
`timescale 1ns / 1ps

// Drives a byte-level I2C controller through one read or write transfer. Send a
// begin word to latch direction, address and count; then pass every controller
// status word in and issue the bus command that comes back. Every word in
// yields exactly one result word. Words are taken at one per cycle unless the
// result side stalls: a word is held in the input register, the transfer state
// is updated and the result is written to the result register. The input
// register takes one more word while a result waits. Write cfg_data with cfg_we
// only while no transfer word is in flight; it sets the limit on address
// attempts for writes.

module i2c_master_transfer_sequencer import i2cms_pkg::*; #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  req_t       req,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output rsp_t       rsp,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data
);

  logic       req_q_valid;
  req_t       req_q;
  logic       fire;
  logic [7:0] max_attempts;
  rsp_t       result;
  seq_stat_t  stat;

  assign fire      = req_q_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = req_q_valid && !fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_attempts <= MAX_ATTEMPTS_RESET;
    end else if (cfg_we) begin
      max_attempts <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_q_valid <= 1'b0;
    end else if (!req_stall) begin
      req_q_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!req_stall && req_valid) begin
      req_q <= req;
    end
  end

  i2cms_fsm #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_fsm (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .word        (req_q),
    .max_attempts(max_attempts),
    .result      (result),
    .stat        (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fire) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp <= result;
    end
  end

  // a failure is only ever reported on the word that ends the transfer
  a_fail_ends: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (!rsp.failed || rsp.finished))
    else $error("failed without finished");

  // received data only comes with a receive or stop command
  a_rx_cmd: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.rx_valid) |->
      (rsp.bus_cmd == CMD_RX_ACK || rsp.bus_cmd == CMD_RX_NACK ||
       rsp.bus_cmd == CMD_STOP))
    else $error("rx data with unexpected command");

  // a busy write has always opened at least one address selection
  a_attempts: assert property (@(posedge clk) disable iff (rst)
    (stat.phase != PH_IDLE && !stat.read_mode) |->
      (stat.attempts_made != 8'd0))
    else $error("busy write with no attempt");

  // a word held in the input register moves on once the result side is free
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (req_q_valid && !rsp_valid) |=> rsp_valid)
    else $error("result not produced");

endmodule

// ===== sim/i2c_master_transfer_sequencer_test.sv =====
// Testbench for the I2C master transfer sequencer: predicted bus commands checked word by word.
`timescale 1ns / 1ps

module i2c_master_transfer_sequencer_test;
  import i2cms_pkg::*;

  localparam int STUCK_LIMIT = 1000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;
  logic cfg_we = 1'b0;
  logic [7:0] cfg_data = '0;

  // Predicted transfer state, advanced once per accepted word.
  phase_t seq_phase = PH_IDLE;
  logic seq_read = 1'b0;
  logic [6:0] seq_addr = '0;
  logic [15:0] seq_left = '0;
  logic [15:0] seq_done = '0;
  logic [7:0] seq_tries = '0;
  logic [7:0] attempt_limit = MAX_ATTEMPTS_RESET;

  rsp_t cmd_q[$];
  int mismatches = 0;
  int hold_left = 0;
  bit quiet = 1'b0;
  int stuck_cycles = 0;

  i2c_master_transfer_sequencer i_dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void end_transfer(inout rsp_t r, input cmd_t c, input logic fail);
    r.bus_cmd = c;
    r.finished = 1'b1;
    r.failed = fail;
    seq_phase = PH_IDLE;
  endfunction

  // Open another address selection, or give up once the limit is used.
  function automatic void select_write(inout rsp_t r);
    if (seq_tries >= attempt_limit) begin
      end_transfer(r, CMD_NONE, 1'b1);
    end else begin
      seq_tries++;
      r.bus_cmd = CMD_START;
      seq_phase = PH_START;
    end
  endfunction

  function automatic void next_read(inout rsp_t r);
    if (seq_left == 0) begin
      end_transfer(r, CMD_STOP, 1'b0);
    end else if (seq_left == 1) begin
      r.bus_cmd = CMD_RX_NACK;
    end else begin
      r.bus_cmd = CMD_RX_ACK;
    end
  endfunction

  function automatic void next_write(inout rsp_t r, input logic [7:0] tx);
    if (seq_left == 0) begin
      end_transfer(r, CMD_STOP, 1'b0);
    end else begin
      r.bus_cmd = CMD_TX;
      r.shift_byte = tx;
      seq_phase = PH_DATA;
    end
  endfunction

  function automatic rsp_t predict_cmd(input req_t w);
    rsp_t r;
    r = '0;
    if (w.func == FUNC_BEGIN) begin
      seq_read = w.is_read;
      seq_addr = w.dev_addr;
      seq_left = w.byte_count;
      seq_done = '0;
      seq_tries = '0;
      if (seq_read) begin
        r.bus_cmd = CMD_START;
        seq_phase = PH_START;
      end else begin
        select_write(r);
      end
    end else if (seq_phase != PH_IDLE && seq_read) begin
      case (seq_phase)
        PH_START: begin
          case (w.bus_status)
            ST_START, ST_RSTART: begin
              r.bus_cmd = CMD_TX;
              r.shift_byte = {seq_addr, 1'b1};
              seq_phase = PH_ADDR;
            end
            ST_ARB_LOST: end_transfer(r, CMD_RELEASE, 1'b1);
            default: end_transfer(r, CMD_STOP, 1'b1);
          endcase
        end
        PH_ADDR: begin
          case (w.bus_status)
            ST_ADDR_ACK: begin
              seq_phase = PH_DATA;
              next_read(r);
            end
            ST_ADDR_NACK: end_transfer(r, CMD_STOP, 1'b0);
            ST_ARB_LOST: end_transfer(r, CMD_RELEASE, 1'b1);
            default: end_transfer(r, CMD_STOP, 1'b1);
          endcase
        end
        default: begin
          if (w.bus_status == ST_DATA_ACK || w.bus_status == ST_DATA_NACK) begin
            r.rx_valid = 1'b1;
            r.rx_data = w.rx_byte;
            seq_done++;
            // a NACKed byte is still kept, then the transfer stops cleanly
            if (w.bus_status == ST_DATA_NACK) begin
              seq_left = '0;
              end_transfer(r, CMD_STOP, 1'b0);
            end else begin
              seq_left--;
              next_read(r);
            end
          end else begin
            end_transfer(r, CMD_STOP, 1'b1);
          end
        end
      endcase
    end else if (seq_phase != PH_IDLE) begin
      case (seq_phase)
        PH_START: begin
          case (w.bus_status)
            ST_START, ST_RSTART: begin
              r.bus_cmd = CMD_TX;
              r.shift_byte = {seq_addr, 1'b0};
              seq_phase = PH_ADDR;
            end
            ST_ARB_LOST: r.bus_cmd = CMD_START;
            default: end_transfer(r, CMD_NONE, 1'b1);
          endcase
        end
        PH_ADDR: begin
          case (w.bus_status)
            ST_ADDR_ACK: next_write(r, w.tx_byte);
            ST_ADDR_NACK: select_write(r);
            ST_ARB_LOST: begin
              r.bus_cmd = CMD_START;
              seq_phase = PH_START;
            end
            default: end_transfer(r, CMD_STOP, 1'b1);
          endcase
        end
        default: begin
          if (w.bus_status == ST_DATA_ACK) begin
            seq_done++;
            seq_left--;
            next_write(r, w.tx_byte);
          end else begin
            end_transfer(r, CMD_STOP, 1'b1);
          end
        end
      endcase
    end
    r.byte_total = seq_done;
    return r;
  endfunction

  function automatic req_t noise_word();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return req_t'(raw[$bits(req_t)-1:0]);
  endfunction

  // Mostly statuses that fit the current phase, with begins, aborts and noise.
  function automatic req_t random_word();
    req_t w;
    int pick;
    w = noise_word();
    pick = $urandom_range(99);
    if ((seq_phase == PH_IDLE && pick < 92) || (seq_phase != PH_IDLE && pick < 4)) begin
      w.func = FUNC_BEGIN;
      pick = $urandom_range(99);
      if (pick < 70) begin
        w.byte_count = 16'($urandom_range(4));
      end else if (pick < 95) begin
        w.byte_count = 16'($urandom_range(20, 5));
      end
      return w;
    end
    w.func = FUNC_STATUS;
    if (seq_phase == PH_IDLE || pick < 12) begin
      return w;
    end
    pick = $urandom_range(99);
    case (seq_phase)
      PH_START: begin
        if (pick >= 85) w.bus_status = ST_ARB_LOST;
        else if (pick[0]) w.bus_status = ST_RSTART;
        else w.bus_status = ST_START;
      end
      PH_ADDR: begin
        if (pick < 75) w.bus_status = ST_ADDR_ACK;
        else if (pick < 90) w.bus_status = ST_ADDR_NACK;
        else w.bus_status = ST_ARB_LOST;
      end
      default: begin
        if (seq_read && pick >= 85) w.bus_status = ST_DATA_NACK;
        else w.bus_status = ST_DATA_ACK;
      end
    endcase
    return w;
  endfunction

  // Called in the time step of a rising edge; returns in the step of the accepting edge.
  task automatic send_word(input req_t w);
    if (!quiet && $urandom_range(99) < 15) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    req <= w;
    req_valid <= 1'b1;
    @(negedge clk);
    while (req_stall !== 1'b0) @(negedge clk);
    @(posedge clk);
    cmd_q.push_back(predict_cmd(w));
  endtask

  task automatic send_begin(input logic rd, input logic [6:0] addr, input logic [15:0] count);
    req_t w;
    w = noise_word();
    w.func = FUNC_BEGIN;
    w.is_read = rd;
    w.dev_addr = addr;
    w.byte_count = count;
    send_word(w);
  endtask

  task automatic send_status(input status_t st, input logic [7:0] rx, input logic [7:0] tx);
    req_t w;
    w = noise_word();
    w.func = FUNC_STATUS;
    w.bus_status = st;
    w.rx_byte = rx;
    w.tx_byte = tx;
    send_word(w);
  endtask

  task automatic run_random(input int n);
    req_t w;
    int counted;
    counted = 0;
    while (counted < n) begin
      w = random_word();
      if (w.func == FUNC_BEGIN || seq_phase != PH_IDLE) counted++;
      send_word(w);
    end
  endtask

  // Hold the sender until every outstanding result has come back.
  task automatic drain();
    req_valid <= 1'b0;
    while (cmd_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_limit(input logic [7:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    attempt_limit = value;
  endtask

  task automatic test_directed_write();
    send_status(ST_OTHER, 8'hFF, 8'hFF);
    send_begin(1'b0, 7'h7F, 16'd2);
    send_status(ST_START, 8'h00, 8'h00);
    send_status(ST_ADDR_ACK, 8'h00, 8'hFF);
    send_status(ST_DATA_ACK, 8'hFF, 8'h00);
    send_status(ST_DATA_ACK, 8'h00, 8'hA5);
  endtask

  task automatic test_directed_read();
    send_begin(1'b1, 7'h00, 16'd2);
    send_status(ST_RSTART, 8'h00, 8'h00);
    send_status(ST_ADDR_ACK, 8'h00, 8'h00);
    send_status(ST_DATA_ACK, 8'hFF, 8'h00);
    send_status(ST_DATA_NACK, 8'h00, 8'hFF);
  endtask

  task automatic test_special_cases();
    // zero-length write stops right after the address
    send_begin(1'b0, 7'h55, 16'd0);
    send_status(ST_START, 8'h00, 8'h00);
    send_status(ST_ADDR_ACK, 8'h00, 8'h3C);
    send_begin(1'b1, 7'h2A, 16'd1);
    send_status(ST_ARB_LOST, 8'h00, 8'h00);
    send_begin(1'b1, 7'h01, 16'hFFFF);
    send_status(ST_START, 8'h00, 8'h00);
    send_status(ST_ADDR_NACK, 8'h00, 8'h00);
    send_begin(1'b0, 7'h40, 16'd1);
    send_status(ST_ADDR_ACK, 8'h00, 8'h00);
    // arbitration loss on a write, then a new begin abandons it
    send_begin(1'b0, 7'h12, 16'd1);
    send_status(ST_ARB_LOST, 8'h00, 8'h00);
    send_status(ST_RSTART, 8'h00, 8'h00);
    send_status(ST_ARB_LOST, 8'h00, 8'h00);
    send_begin(1'b1, 7'h34, 16'd1);
    send_status(ST_OTHER, 8'h00, 8'h00);
  endtask

  task automatic test_attempt_limit();
    set_limit(8'd1);
    send_begin(1'b0, 7'h21, 16'd1);
    send_status(ST_START, 8'h00, 8'h00);
    send_status(ST_ADDR_NACK, 8'h00, 8'h00);
    run_random(100);
    set_limit(8'd2);
    run_random(100);
  endtask

  task automatic test_backpressure();
    set_limit(8'd255);
    hold_left = 80;
    run_random(40);
    drain();
  endtask

  task automatic test_no_idle();
    quiet = 1'b1;
    set_limit(8'($urandom_range(255, 1)));
    run_random(150);
    drain();
    quiet = 1'b0;
  endtask

  task automatic test_random();
    set_limit(MAX_ATTEMPTS_RESET);
    run_random(500);
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      rsp_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      rsp_stall <= !quiet && ($urandom_range(99) < 15);
    end
  end

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Outputs are stable from the falling edge until the accepting rising edge.
  always @(negedge clk) begin : check_results
    rsp_t want;
    if (!rst && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
      if (cmd_q.size() == 0) begin
        $error("result word with no command expected");
        mismatches++;
      end else begin
        want = cmd_q.pop_front();
        check_field("bus_cmd", 16'(want.bus_cmd), 16'(rsp.bus_cmd));
        check_field("shift_byte", 16'(want.shift_byte), 16'(rsp.shift_byte));
        check_field("rx_valid", 16'(want.rx_valid), 16'(rsp.rx_valid));
        check_field("rx_data", 16'(want.rx_data), 16'(rsp.rx_data));
        check_field("finished", 16'(want.finished), 16'(rsp.finished));
        check_field("failed", 16'(want.failed), 16'(rsp.failed));
        check_field("byte_total", want.byte_total, rsp.byte_total);
      end
    end
  end

  always @(negedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) stuck_cycles = 0;
    else stuck_cycles++;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed_write();
    test_directed_read();
    test_special_cases();
    test_attempt_limit();
    test_backpressure();
    test_no_idle();
    test_random();
    drain();
    repeat (4) @(posedge clk);
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

// ===== i2c_master_transfer_sequencer.f =====
rtl/i2cms_pkg.sv
rtl/i2cms_fsm.sv
rtl/i2c_master_transfer_sequencer.sv
sim/i2c_master_transfer_sequencer_test.sv
